// ===== src/bta_pkg.sv =====
package bta_pkg;

   localparam int CmdWidth    = 3;
   localparam int TimeWidth   = 64;
   localparam int JobWidth    = 16;
   localparam int FreqWidth   = 32;
   localparam int WinMsWidth  = 16;
   localparam int NsPerMsWidth = 20;
   localparam int WinNsWidth  = WinMsWidth + NsPerMsWidth;

   localparam logic [NsPerMsWidth-1:0] NS_PER_MS = 20'd1_000_000;
   localparam logic [WinMsWidth-1:0]   WINDOW_MS_RESET = 16'd16;

   localparam logic [CmdWidth-1:0] CMD_JOB_START   = 3'd0;
   localparam logic [CmdWidth-1:0] CMD_JOB_END     = 3'd1;
   localparam logic [CmdWidth-1:0] CMD_CAPTURE     = 3'd2;
   localparam logic [CmdWidth-1:0] CMD_FREQ_CHANGE = 3'd3;
   localparam logic [CmdWidth-1:0] CMD_TRACE_START = 3'd4;
   localparam logic [CmdWidth-1:0] CMD_TRACE_STOP  = 3'd5;

   typedef struct packed {
      logic [CmdWidth-1:0]  cmd;
      logic [TimeWidth-1:0] timestamp_ns;
      logic [JobWidth-1:0]  job_delta;
      logic                 compute_job;
      logic [FreqWidth-1:0] new_freq;
   } req_type;

   typedef struct packed {
      logic [TimeWidth-1:0]       reported_total;
      logic [TimeWidth-1:0]       reported_busy;
      logic [TimeWidth-1:0]       compute_busy;
      logic                       window_closed;
      logic                       report_updated;
      logic signed [JobWidth-1:0] active_jobs;
      logic                       count_error;
   } rsp_type;

endpackage

// ===== src/bta_in_reg.sv =====
module bta_in_reg
   import bta_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_take,
   output req_type out_data
);

   logic    valid_ff, valid_in;
   req_type data_ff;

   assign in_ready  = !valid_ff || out_take;
   assign valid_in  = (in_valid && in_ready) ? 1'b1 : (out_take ? 1'b0 : valid_ff);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

// ===== src/bta_engine.sv =====
module bta_engine
   import bta_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [WinMsWidth-1:0] csr_wr_data,
   input  logic                  take,
   input  req_type               req,
   output rsp_type               rsp
);

   logic [WinNsWidth-1:0] window_ns_ff, window_ns_in;

   logic [JobWidth-1:0]  active_ff, active_in;
   logic [JobWidth-1:0]  cactive_ff, cactive_in;
   logic [TimeWidth-1:0] last_ff, last_in;
   logic [TimeWidth-1:0] clast_ff, clast_in;
   logic [TimeWidth-1:0] total_ff, total_in;
   logic [TimeWidth-1:0] busy_ff, busy_in;
   logic [TimeWidth-1:0] cbusy_ff, cbusy_in;
   logic [TimeWidth-1:0] prev_total_ff, prev_total_in;
   logic [TimeWidth-1:0] prev_busy_ff, prev_busy_in;
   logic [TimeWidth-1:0] prev_cbusy_ff, prev_cbusy_in;
   logic [TimeWidth-1:0] stat_total_ff, stat_total_in;
   logic [TimeWidth-1:0] stat_busy_ff, stat_busy_in;
   logic [FreqWidth-1:0] freq_ff, freq_in;

   logic [TimeWidth-1:0] dt, dct;
   logic [TimeWidth-1:0] cap_total, cap_busy, cap_cbusy, cap_diff;
   logic [JobWidth-1:0]  start_active, start_cactive, end_active, end_cactive;
   logic                 active_pos, cactive_pos, window_hit;
   logic                 closed, updated, err;

   // product is registered at the write so the capture path only compares
   assign window_ns_in = csr_wr_en ? WinNsWidth'(csr_wr_data) * WinNsWidth'(NS_PER_MS)
                                   : window_ns_ff;

   assign dt  = req.timestamp_ns - last_ff;
   assign dct = req.timestamp_ns - clast_ff;

   assign start_active  = active_ff + req.job_delta;
   assign start_cactive = cactive_ff + req.job_delta;
   assign end_active    = active_ff - req.job_delta;
   assign end_cactive   = cactive_ff - req.job_delta;

   assign active_pos  = !active_ff[JobWidth-1] && (active_ff != '0);
   assign cactive_pos = !cactive_ff[JobWidth-1] && (cactive_ff != '0);

   assign cap_total  = total_ff + dt;
   assign cap_busy   = active_pos ? busy_ff + dt : busy_ff;
   assign cap_cbusy  = (active_pos && cactive_pos) ? cbusy_ff + dct : cbusy_ff;
   assign cap_diff   = cap_total - prev_total_ff;
   assign window_hit = cap_diff >= TimeWidth'(window_ns_ff);

   always_comb begin
      active_in     = active_ff;
      cactive_in    = cactive_ff;
      last_in       = last_ff;
      clast_in      = clast_ff;
      total_in      = total_ff;
      busy_in       = busy_ff;
      cbusy_in      = cbusy_ff;
      prev_total_in = prev_total_ff;
      prev_busy_in  = prev_busy_ff;
      prev_cbusy_in = prev_cbusy_ff;
      stat_total_in = stat_total_ff;
      stat_busy_in  = stat_busy_ff;
      freq_in       = freq_ff;
      closed        = 1'b0;
      updated       = 1'b0;
      err           = 1'b0;
      case (req.cmd)
         CMD_JOB_START: begin
            if (req.job_delta != '0) begin
               if (active_ff == '0) begin
                  total_in = total_ff + dt;
                  last_in  = req.timestamp_ns;
                  if (req.compute_job) begin
                     clast_in = req.timestamp_ns;
                  end
               end else if (req.compute_job && cactive_ff == '0) begin
                  clast_in = req.timestamp_ns;
               end
               active_in = start_active;
               if (req.compute_job) begin
                  cactive_in = start_cactive;
               end
               err = start_active[JobWidth-1];
            end
         end
         CMD_JOB_END: begin
            if (req.job_delta != '0) begin
               active_in = end_active;
               if (req.compute_job) begin
                  cactive_in = end_cactive;
               end
               if (end_active == '0) begin
                  busy_in  = busy_ff + dt;
                  total_in = total_ff + dt;
                  last_in  = req.timestamp_ns;
                  if (req.compute_job) begin
                     cbusy_in = cbusy_ff + dct;
                     clast_in = req.timestamp_ns;
                  end
               end else if (req.compute_job && end_cactive == '0) begin
                  cbusy_in = cbusy_ff + dct;
                  clast_in = req.timestamp_ns;
               end
               err = end_active[JobWidth-1];
            end
         end
         CMD_CAPTURE: begin
            last_in  = req.timestamp_ns;
            clast_in = req.timestamp_ns;
            total_in = cap_total;
            busy_in  = cap_busy;
            cbusy_in = cap_cbusy;
            if (window_hit) begin
               total_in      = cap_diff;
               prev_total_in = cap_diff;
               busy_in       = cap_busy - prev_busy_ff;
               prev_busy_in  = cap_busy - prev_busy_ff;
               cbusy_in      = cap_cbusy - prev_cbusy_ff;
               prev_cbusy_in = cap_cbusy - prev_cbusy_ff;
               stat_total_in = cap_diff;
               stat_busy_in  = cap_busy - prev_busy_ff;
               closed        = 1'b1;
               updated       = 1'b1;
            end else if (prev_total_ff != '0) begin
               stat_total_in = cap_total;
               stat_busy_in  = cap_busy;
               updated       = 1'b1;
            end
         end
         CMD_FREQ_CHANGE: begin
            if (freq_ff != req.new_freq) begin
               freq_in       = req.new_freq;
               last_in       = req.timestamp_ns;
               clast_in      = req.timestamp_ns;
               total_in      = '0;
               busy_in       = '0;
               cbusy_in      = '0;
               prev_total_in = '0;
               prev_busy_in  = '0;
               prev_cbusy_in = '0;
            end
         end
         CMD_TRACE_START: begin
            last_in       = req.timestamp_ns;
            clast_in      = req.timestamp_ns;
            total_in      = '0;
            busy_in       = '0;
            cbusy_in      = '0;
            prev_total_in = '0;
            prev_busy_in  = '0;
            prev_cbusy_in = '0;
         end
         CMD_TRACE_STOP: begin
            total_in      = '0;
            busy_in       = '0;
            cbusy_in      = '0;
            prev_total_in = '0;
            prev_busy_in  = '0;
            prev_cbusy_in = '0;
            stat_total_in = '0;
            stat_busy_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp.reported_total = stat_total_in;
      rsp.reported_busy  = stat_busy_in;
      rsp.compute_busy   = cbusy_in;
      rsp.window_closed  = closed;
      rsp.report_updated = updated;
      rsp.active_jobs    = active_in;
      rsp.count_error    = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ns_ff  <= WinNsWidth'(WINDOW_MS_RESET) * WinNsWidth'(NS_PER_MS);
         active_ff     <= '0;
         cactive_ff    <= '0;
         last_ff       <= '0;
         clast_ff      <= '0;
         total_ff      <= '0;
         busy_ff       <= '0;
         cbusy_ff      <= '0;
         prev_total_ff <= '0;
         prev_busy_ff  <= '0;
         prev_cbusy_ff <= '0;
         stat_total_ff <= '0;
         stat_busy_ff  <= '0;
         freq_ff       <= '0;
      end else begin
         window_ns_ff <= window_ns_in;
         if (take) begin
            active_ff     <= active_in;
            cactive_ff    <= cactive_in;
            last_ff       <= last_in;
            clast_ff      <= clast_in;
            total_ff      <= total_in;
            busy_ff       <= busy_in;
            cbusy_ff      <= cbusy_in;
            prev_total_ff <= prev_total_in;
            prev_busy_ff  <= prev_busy_in;
            prev_cbusy_ff <= prev_cbusy_in;
            stat_total_ff <= stat_total_in;
            stat_busy_ff  <= stat_busy_in;
            freq_ff       <= freq_in;
         end
      end
   end

endmodule

// ===== src/bta_out_reg.sv =====
module bta_out_reg
   import bta_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_take,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign in_take   = in_valid && (!valid_ff || out_ready);
   assign valid_in  = in_take ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         data_ff <= in_data;
      end
   end

endmodule

// ===== src/gpu_busy_time_accounting_top.sv =====
// channel   direction  handshake                 payload
// req       in         req_valid / req_ready     cmd, timestamp, job count, compute flag, freq
// rsp       out        rsp_valid / rsp_ready     reported totals, compute busy, flags, count
// csr       in         csr_wr_en, no wait        window length in ms
//
// one request per cycle while rsp_ready keeps the output register draining; a request goes
// into the input register, then its accounting update into the output register (rsp_valid)
// synchronous active-high reset clears all counters and sets the window to 16 ms
// a stalled rsp holds the output register; the input register still takes one more request
module gpu_busy_time_accounting_top
   import bta_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CmdWidth-1:0]        req_cmd,
   input  logic [TimeWidth-1:0]       req_timestamp_ns,
   input  logic [JobWidth-1:0]        req_job_delta,
   input  logic                       req_compute_job,
   input  logic [FreqWidth-1:0]       req_new_freq,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [TimeWidth-1:0]       rsp_reported_total,
   output logic [TimeWidth-1:0]       rsp_reported_busy,
   output logic [TimeWidth-1:0]       rsp_compute_busy,
   output logic                       rsp_window_closed,
   output logic                       rsp_report_updated,
   output logic signed [JobWidth-1:0] rsp_active_jobs,
   output logic                       rsp_count_error,
   input  logic                       csr_wr_en,
   input  logic [WinMsWidth-1:0]      csr_wr_data
);

   req_type req_in, req_held;
   rsp_type rsp_next, rsp_out;
   logic    held_valid, take;

   assign req_in.cmd          = req_cmd;
   assign req_in.timestamp_ns = req_timestamp_ns;
   assign req_in.job_delta    = req_job_delta;
   assign req_in.compute_job  = req_compute_job;
   assign req_in.new_freq     = req_new_freq;

   bta_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_in),
      .out_valid (held_valid),
      .out_take  (take),
      .out_data  (req_held)
   );

   bta_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .take        (take),
      .req         (req_held),
      .rsp         (rsp_next)
   );

   bta_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (held_valid),
      .in_take   (take),
      .in_data   (rsp_next),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_out)
   );

   assign rsp_reported_total = rsp_out.reported_total;
   assign rsp_reported_busy  = rsp_out.reported_busy;
   assign rsp_compute_busy   = rsp_out.compute_busy;
   assign rsp_window_closed  = rsp_out.window_closed;
   assign rsp_report_updated = rsp_out.report_updated;
   assign rsp_active_jobs    = rsp_out.active_jobs;
   assign rsp_count_error    = rsp_out.count_error;

endmodule

// ===== tb/gpu_busy_time_accounting_top_test.sv =====
`timescale 1ns / 100ps

module gpu_busy_time_accounting_top_test;
   import bta_pkg::*;

   localparam logic [CmdWidth-1:0] CMD_RSVD_A = 3'd6;
   localparam logic [CmdWidth-1:0] CMD_RSVD_B = 3'd7;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [CmdWidth-1:0]        req_cmd = '0;
   logic [TimeWidth-1:0]       req_timestamp_ns = '0;
   logic [JobWidth-1:0]        req_job_delta = '0;
   logic                       req_compute_job = 1'b0;
   logic [FreqWidth-1:0]       req_new_freq = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [TimeWidth-1:0]       rsp_reported_total;
   logic [TimeWidth-1:0]       rsp_reported_busy;
   logic [TimeWidth-1:0]       rsp_compute_busy;
   logic                       rsp_window_closed;
   logic                       rsp_report_updated;
   logic signed [JobWidth-1:0] rsp_active_jobs;
   logic                       rsp_count_error;
   logic                       csr_wr_en = 1'b0;
   logic [WinMsWidth-1:0]      csr_wr_data = '0;

   gpu_busy_time_accounting_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_timestamp_ns   (req_timestamp_ns),
      .req_job_delta      (req_job_delta),
      .req_compute_job    (req_compute_job),
      .req_new_freq       (req_new_freq),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_reported_total (rsp_reported_total),
      .rsp_reported_busy  (rsp_reported_busy),
      .rsp_compute_busy   (rsp_compute_busy),
      .rsp_window_closed  (rsp_window_closed),
      .rsp_report_updated (rsp_report_updated),
      .rsp_active_jobs    (rsp_active_jobs),
      .rsp_count_error    (rsp_count_error),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #4 clock = ~clock;

   // accounting state mirrored from the block
   logic [WinMsWidth-1:0] win_ms;
   logic [JobWidth-1:0]   act_cnt, cact_cnt;
   logic [TimeWidth-1:0]  mark_ns, cmark_ns;
   logic [TimeWidth-1:0]  total_ns, busy_ns, cbusy_ns;
   logic [TimeWidth-1:0]  base_total, base_busy, base_cbusy;
   logic [TimeWidth-1:0]  shown_total, shown_busy;
   logic [FreqWidth-1:0]  freq_hz;

   rsp_type               pending_q[$];
   logic [TimeWidth-1:0]  ts_now;
   bit                    steady_mode = 1'b0;
   int                    rsp_hold = 0;
   int                    request_cnt = 0;
   int                    rsp_seen = 0;
   int                    closed_cnt = 0;
   int                    error_cnt = 0;
   int                    mismatch_cnt = 0;
   logic [WinMsWidth-1:0] win_rand_a, win_rand_b;

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void clear_window_sums();
      total_ns = '0;
      busy_ns = '0;
      cbusy_ns = '0;
      base_total = '0;
      base_busy = '0;
      base_cbusy = '0;
   endfunction

   function automatic rsp_type account_event(input req_type rq);
      rsp_type              rs;
      logic [TimeWidth-1:0] t;
      logic [TimeWidth-1:0] win_ns;
      logic                 neg;
      t = rq.timestamp_ns;
      win_ns = 64'(win_ms) * 64'(NS_PER_MS);
      rs = '0;
      neg = 1'b0;
      case (rq.cmd)
         CMD_JOB_START: begin
            if (rq.job_delta != 0) begin
               if (act_cnt == 0) begin
                  total_ns += t - mark_ns;
                  mark_ns = t;
                  if (rq.compute_job)
                     cmark_ns = t;
               end else if (rq.compute_job && cact_cnt == 0) begin
                  cmark_ns = t;
               end
               act_cnt += rq.job_delta;
               if (rq.compute_job)
                  cact_cnt += rq.job_delta;
               neg = act_cnt[JobWidth-1];
            end
         end
         CMD_JOB_END: begin
            if (rq.job_delta != 0) begin
               act_cnt -= rq.job_delta;
               if (rq.compute_job)
                  cact_cnt -= rq.job_delta;
               if (act_cnt == 0) begin
                  busy_ns += t - mark_ns;
                  total_ns += t - mark_ns;
                  mark_ns = t;
                  if (rq.compute_job) begin
                     cbusy_ns += t - cmark_ns;
                     cmark_ns = t;
                  end
               end else if (rq.compute_job && cact_cnt == 0) begin
                  cbusy_ns += t - cmark_ns;
                  cmark_ns = t;
               end
               neg = act_cnt[JobWidth-1];
            end
         end
         CMD_CAPTURE: begin
            total_ns += t - mark_ns;
            if (!act_cnt[JobWidth-1] && act_cnt != 0) begin
               busy_ns += t - mark_ns;
               if (!cact_cnt[JobWidth-1] && cact_cnt != 0)
                  cbusy_ns += t - cmark_ns;
            end
            mark_ns = t;
            cmark_ns = t;
            if (total_ns - base_total >= win_ns) begin
               total_ns -= base_total;
               base_total = total_ns;
               busy_ns -= base_busy;
               base_busy = busy_ns;
               cbusy_ns -= base_cbusy;
               base_cbusy = cbusy_ns;
               shown_total = total_ns;
               shown_busy = busy_ns;
               rs.window_closed = 1'b1;
               rs.report_updated = 1'b1;
            end else if (base_total != 0) begin
               shown_total = total_ns;
               shown_busy = busy_ns;
               rs.report_updated = 1'b1;
            end
         end
         CMD_FREQ_CHANGE: begin
            if (freq_hz != rq.new_freq) begin
               freq_hz = rq.new_freq;
               mark_ns = t;
               cmark_ns = t;
               clear_window_sums();
            end
         end
         CMD_TRACE_START: begin
            clear_window_sums();
            mark_ns = t;
            cmark_ns = t;
         end
         CMD_TRACE_STOP: begin
            clear_window_sums();
            shown_total = '0;
            shown_busy = '0;
         end
         default: ;
      endcase
      rs.reported_total = shown_total;
      rs.reported_busy = shown_busy;
      rs.compute_busy = cbusy_ns;
      rs.active_jobs = act_cnt;
      rs.count_error = neg;
      return rs;
   endfunction

   function automatic string rsp_text(input rsp_type r);
      return $sformatf("total=%h busy=%h cbusy=%h closed=%b updated=%b active=%0d err=%b",
                       r.reported_total, r.reported_busy, r.compute_busy, r.window_closed,
                       r.report_updated, r.active_jobs, r.count_error);
   endfunction

   task automatic send_request(input logic [CmdWidth-1:0] cmd, input logic [TimeWidth-1:0] ts,
                               input logic [JobWidth-1:0] jobs, input logic cu,
                               input logic [FreqWidth-1:0] freq);
      req_type rq;
      rsp_type rs;
      int      gap;
      rq = '{cmd, ts, jobs, cu, freq};
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_timestamp_ns <= ts;
      req_job_delta <= jobs;
      req_compute_job <= cu;
      req_new_freq <= freq;
      do
         @(posedge clock);
      while (!req_ready);
      rs = account_event(rq);
      pending_q.push_back(rs);
      request_cnt++;
      if (rs.window_closed)
         closed_cnt++;
      if (rs.count_error)
         error_cnt++;
      gap = steady_mode ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      wait (pending_q.size() == 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_window(input logic [WinMsWidth-1:0] ms);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= ms;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      win_ms = ms;
   endtask

   // mostly well-formed job traffic on a rising clock, some raw noise
   task automatic random_traffic(input int n);
      int                    pick;
      logic [TimeWidth-1:0]  span;
      logic [JobWidth-1:0]   jobs;
      logic [CmdWidth-1:0]   cmd;
      logic                  cu;
      span = ((win_ms == 0) ? 64'(NS_PER_MS) : 64'(win_ms) * 64'(NS_PER_MS)) / 6;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_request(CmdWidth'($urandom_range(0, 7)), {$urandom, $urandom},
                         JobWidth'($urandom), 1'($urandom), $urandom);
         end else begin
            ts_now += span * $urandom_range(0, 1000) / 1000;
            jobs = JobWidth'($urandom_range(1, 3));
            cu = 1'($urandom);
            if (pick < 40)
               cmd = CMD_JOB_START;
            else if (pick < 70)
               cmd = CMD_JOB_END;
            else if (pick < 90)
               cmd = CMD_CAPTURE;
            else if (pick < 94)
               cmd = CMD_FREQ_CHANGE;
            else if (pick < 97)
               cmd = CMD_TRACE_START;
            else
               cmd = CMD_TRACE_STOP;
            // pull a drifted job count back toward a sane range
            if (act_cnt[JobWidth-1]) begin
               cmd = CMD_JOB_START;
               jobs = -act_cnt;
            end else if (act_cnt > 16'd24) begin
               cmd = CMD_JOB_END;
               jobs = act_cnt - 1;
            end else if (cmd == CMD_JOB_END && act_cnt != 0 && jobs > act_cnt) begin
               jobs = act_cnt;
            end
            if (cmd == CMD_JOB_END && (cact_cnt[JobWidth-1] || cact_cnt < jobs))
               cu = 1'b0;
            if (cmd == CMD_JOB_START && cact_cnt[JobWidth-1])
               cu = 1'b1;
            send_request(cmd, ts_now, jobs, cu, $urandom_range(0, 2) * 32'd500_000_000);
         end
      end
   endtask

   task automatic test_reporting_window();
      send_request(CMD_JOB_START, 64'd1000, 16'd1, 1'b1, 32'd0);
      send_request(CMD_CAPTURE, 64'd2_000_000, 16'd0, 1'b0, 32'd0);
      send_request(CMD_JOB_END, 64'd6_000_000, 16'd1, 1'b1, 32'd0);
      send_request(CMD_CAPTURE, 64'd20_000_000, 16'd0, 1'b0, 32'd0);
      // under the window but with a closed one behind: refresh only
      send_request(CMD_CAPTURE, 64'd21_000_000, 16'd0, 1'b0, 32'd0);
      send_request(CMD_JOB_START, 64'd21_500_000, 16'd0, 1'b1, 32'd0);
      send_request(CMD_JOB_END, 64'd21_600_000, 16'd0, 1'b0, 32'd0);
   endtask

   task automatic test_basic_events();
      send_request(CMD_FREQ_CHANGE, 64'd30_000_000, 16'd0, 1'b0, '1);
      send_request(CMD_FREQ_CHANGE, 64'd31_000_000, 16'd0, 1'b0, '1);
      send_request(CMD_FREQ_CHANGE, 64'd32_000_000, 16'd0, 1'b0, 32'd0);
      send_request(CMD_TRACE_START, 64'd40_000_000, 16'd0, 1'b0, 32'd0);
      send_request(CMD_JOB_START, 64'd41_000_000, 16'd2, 1'b1, 32'd0);
      send_request(CMD_TRACE_STOP, 64'd42_000_000, 16'd0, 1'b0, 32'd0);
      send_request(CMD_RSVD_A, '1, '1, 1'b1, '1);
      send_request(CMD_RSVD_B, '0, '0, 1'b0, '0);
      // timestamp at the top of the range, then wrapping to zero
      send_request(CMD_CAPTURE, '1, 16'd0, 1'b0, 32'd0);
      send_request(CMD_CAPTURE, '0, 16'd0, 1'b0, 32'd0);
      send_request(CMD_JOB_END, 64'd100, 16'd2, 1'b1, 32'd0);
   endtask

   task automatic test_count_wrap();
      send_request(CMD_JOB_START, 64'd1000, '1, 1'b1, 32'd0);
      send_request(CMD_JOB_START, 64'd2000, 16'd1, 1'b0, 32'd0);
      send_request(CMD_JOB_START, 64'd3000, 16'h8000, 1'b1, 32'd0);
      send_request(CMD_JOB_END, 64'd4000, 16'h8000, 1'b1, 32'd0);
      send_request(CMD_JOB_END, 64'd5000, 16'd1, 1'b0, 32'd0);
      send_request(CMD_JOB_START, 64'd6000, 16'd1, 1'b0, 32'd0);
   endtask

   task automatic test_default_window();
      ts_now = 64'd50_000_000;
      random_traffic(150);
   endtask

   task automatic test_short_window();
      set_window(16'd1);
      random_traffic(150);
   endtask

   task automatic test_zero_window();
      set_window(16'd0);
      random_traffic(100);
   endtask

   task automatic test_long_window();
      set_window(16'hFFFF);
      random_traffic(150);
   endtask

   task automatic test_back_to_back();
      set_window(win_rand_a);
      steady_mode = 1'b1;
      random_traffic(150);
      steady_mode = 1'b0;
   endtask

   task automatic test_timestamp_wrap();
      set_window(16'd3);
      ts_now = '1 - 64'd5_000_000;
      random_traffic(100);
   endtask

   task automatic test_random_window();
      set_window(win_rand_b);
      random_traffic(200);
   endtask

   // response side stalls
   always @(posedge clock) begin
      if (rsp_hold > 0 && !steady_mode) begin
         rsp_ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         rsp_hold <= ($urandom_range(0, 3) == 0) ? idle_gap() : 0;
      end
   end

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_reported_total, rsp_reported_busy, rsp_compute_busy, rsp_window_closed,
                 rsp_report_updated, rsp_active_jobs, rsp_count_error};
         if (pending_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("response with no request pending: %s", rsp_text(got));
         end else begin
            want = pending_q.pop_front();
            if (got.reported_total !== want.reported_total ||
                got.reported_busy !== want.reported_busy ||
                got.compute_busy !== want.compute_busy ||
                got.window_closed !== want.window_closed ||
                got.report_updated !== want.report_updated ||
                got.active_jobs !== want.active_jobs ||
                got.count_error !== want.count_error) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10) begin
                  $display("mismatch on response %0d", rsp_seen);
                  $display("   expected %s", rsp_text(want));
                  $display("   actual   %s", rsp_text(got));
               end
            end
            rsp_seen++;
         end
      end
   end

   initial begin
      win_ms = WINDOW_MS_RESET;
      act_cnt = '0;
      cact_cnt = '0;
      mark_ns = '0;
      cmark_ns = '0;
      clear_window_sums();
      shown_total = '0;
      shown_busy = '0;
      freq_hz = '0;
      ts_now = '0;
      win_rand_a = WinMsWidth'($urandom_range(2, 200));
      win_rand_b = WinMsWidth'($urandom_range(1, 65535));
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reporting_window();
      test_basic_events();
      test_count_wrap();
      test_default_window();
      test_short_window();
      test_zero_window();
      test_long_window();
      test_back_to_back();
      test_timestamp_wrap();
      test_random_window();
      wait_idle();
      $display("%0d requests checked, %0d windows closed, %0d negative-count flags", request_cnt,
               closed_cnt, error_cnt);
      $display("windows of 16, 1, 0, 65535, %0d and %0d ms, plus a timestamp wrap",
               win_rand_a, win_rand_b);
      if (mismatch_cnt == 0 && pending_q.size() == 0)
         $display("gpu_busy_time_accounting_top_test passed");
      else
         $display("gpu_busy_time_accounting_top_test failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d responses outstanding", pending_q.size());
      $display("gpu_busy_time_accounting_top_test failed");
      $finish;
   end

endmodule
